/* rtl/id3_pkg.sv */
// Package with the shared types and constants of the ID3v2 text frame extractor.
`timescale 1ns / 1ps
package id3_pkg;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       restart;
	} in_word_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       field;
		logic [7:0] text_byte;
	} out_word_t;

	typedef enum logic [2:0] {
		KIND_TEXT     = 3'd0,
		KIND_FIELD    = 3'd1,
		KIND_TAG_DONE = 3'd2,
		KIND_NOT_ID3  = 3'd3,
		KIND_BAD_VER  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_HDR     = 3'd1,
		PH_EXT     = 3'd2,
		PH_EXTSKIP = 3'd3,
		PH_FHDR    = 3'd4,
		PH_FBODY   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		FK_UNKNOWN = 2'd0,
		FK_ARTIST  = 2'd1,
		FK_TITLE   = 2'd2
	} field_kind_t;

	typedef enum logic [1:0] {
		BOM_NONE = 2'd0,
		BOM_LE   = 2'd1,
		BOM_BE   = 2'd2
	} bom_t;

	// One parsed step: up to five result words, packed in delivery order.
	typedef struct packed {
		logic [2:0]            count;
		out_word_t [4:0]       words;
	} batch_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam logic [7:0]  MAX_TEXT_LEN_RESET = 8'd64;
	localparam logic [23:0] ID_TP1  = 24'h545031;
	localparam logic [23:0] ID_TT2  = 24'h545432;
	localparam logic [31:0] ID_TPE1 = 32'h54504531;
	localparam logic [31:0] ID_TIT2 = 32'h54495432;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] r;
		begin
			case (idx)
				2'd0: r = 8'h49;
				2'd1: r = 8'h44;
				default: r = 8'h33;
			endcase
			return r;
		end
	endfunction

endpackage

/* rtl/id3v2_text_frame_extractor_unit.sv */
// Top level of the ID3v2 text frame extractor.
// Emits text words of artist and title frames (UTF-16 turned into UTF-8, other encodings
// as received), field-end and status words. A tag byte is accepted every cycle while the
// four-entry result queue has room; each byte yields up to five result words, which leave
// one per cycle while out_stall is low, so the output port sets the sustained rate.
`timescale 1ns / 1ps
module id3v2_text_frame_extractor_unit import id3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_word_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_data,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic [7:0] max_text_len_q;
	logic       room;
	logic       take;
	logic       bvalid;
	batch_t     batch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_text_len_q <= MAX_TEXT_LEN_RESET;
		else if (cfg_we) max_text_len_q <= cfg_wdata;
	end

	assign in_stall = !room;

	id3_front u_front (
		.clk, .arst_n,
		.in_valid(in_valid && room),
		.in_word(in_data),
		.max_text_len(max_text_len_q),
		.take,
		.batch_valid(bvalid),
		.batch
	);

	id3_back u_back (
		.clk, .arst_n,
		.push(bvalid && take),
		.batch,
		.room,
		.out_valid,
		.out_word(out_data),
		.out_stall
	);

endmodule

/* rtl/id3_front.sv */
// Front part: parses the tag byte stream and forms the result words of each byte.
`timescale 1ns / 1ps
module id3_front import id3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  in_word_t   in_word,
	input  logic [7:0] max_text_len,
	output logic       take,
	output logic       batch_valid,
	output batch_t     batch
);

	phase_t      phase_q;
	logic [3:0]  byte_count_q;
	logic [7:0]  version_q;
	logic [7:0]  flags_q;
	logic [31:0] tag_left_q;
	logic [31:0] ext_left_q;
	logic [31:0] frame_id_q;
	logic [31:0] frame_left_q;
	field_kind_t fk_q;
	logic [7:0]  enc_q;
	bom_t        bom_q;
	logic [7:0]  held_q;
	logic [7:0]  emitted_q;
	logic        stopped_q;

	phase_t      phase_d;
	logic [3:0]  byte_count_d;
	logic [7:0]  version_d;
	logic [7:0]  flags_d;
	logic [31:0] tag_left_d;
	logic [31:0] ext_left_d;
	logic [31:0] frame_id_d;
	logic [31:0] frame_left_d;
	field_kind_t fk_d;
	logic [7:0]  enc_d;
	bom_t        bom_d;
	logic [7:0]  held_d;
	logic [7:0]  emitted_d;
	logic        stopped_d;
	batch_t      b_d;

	assign take = in_valid;

	always_comb begin
		logic [7:0]  b;
		logic [15:0] u;
		logic [7:0]  tx [3];
		logic [1:0]  ntx;
		logic        fld;
		logic        fk_known;
		logic [3:0]  hlen;
		logic [3:0]  idlen;
		logic [31:0] tl_dec;
		logic [31:0] fl_dec;
		logic [31:0] ext_new;
		logic [31:0] fl_new;
		logic [8:0]  lim;
		logic        unit_done;
		b = in_word.byte_in;
		phase_d = phase_q; byte_count_d = byte_count_q; version_d = version_q;
		flags_d = flags_q; tag_left_d = tag_left_q; ext_left_d = ext_left_q;
		frame_id_d = frame_id_q; frame_left_d = frame_left_q; fk_d = fk_q;
		enc_d = enc_q; bom_d = bom_q; held_d = held_q; emitted_d = emitted_q;
		stopped_d = stopped_q;
		b_d = '0;
		u = '0; ntx = '0; tx[0] = '0; tx[1] = '0; tx[2] = '0;
		ext_new = '0; fl_new = '0; lim = '0; unit_done = 1'b0;
		if (in_word.restart) begin
			phase_d = PH_HDR; byte_count_d = '0; version_d = '0; flags_d = '0;
			tag_left_d = '0; ext_left_d = '0; frame_id_d = '0; frame_left_d = '0;
			fk_d = FK_UNKNOWN; enc_d = '0; bom_d = BOM_NONE; held_d = '0;
			emitted_d = '0; stopped_d = 1'b0;
		end
		fld = (fk_d == FK_TITLE);
		fk_known = (fk_d != FK_UNKNOWN);
		hlen = (version_d == 8'd2) ? 4'd6 : 4'd10;
		idlen = (version_d == 8'd2) ? 4'd3 : 4'd4;
		tl_dec = tag_left_d - 32'd1;
		fl_dec = frame_left_d - 32'd1;
		unique case (phase_d)
			PH_HDR: begin
				if (byte_count_d < 4'd3 && b != magic_byte(byte_count_d[1:0])) begin
					b_d.words[0] = '{kind: KIND_NOT_ID3, field: 1'b0, text_byte: 8'd0};
					b_d.count = 3'd1;
					phase_d = PH_IDLE;
				end else begin
					if (byte_count_d == 4'd3) version_d = b;
					else if (byte_count_d == 4'd5) flags_d = b;
					else if (byte_count_d >= 4'd6)
						tag_left_d = {tag_left_d[24:0], b[6:0]};
					byte_count_d = byte_count_d + 4'd1;
					if (byte_count_d == 4'd10) begin
						byte_count_d = '0;
						if ({tag_left_d} == 32'd0) begin
							b_d.words[0] = '{kind: KIND_TAG_DONE, field: 1'b0, text_byte: 8'd0};
							b_d.count = 3'd1;
							phase_d = PH_IDLE;
						end else begin
							phase_d = flags_d[6] ? PH_EXT : PH_FHDR;
						end
					end
				end
			end
			PH_EXT: begin
				tag_left_d = tl_dec;
				ext_new = {ext_left_d[24:0], b[6:0]};
				ext_left_d = ext_new;
				byte_count_d = byte_count_d + 4'd1;
				if (tl_dec == 32'd0) begin
					b_d.words[0] = '{kind: KIND_TAG_DONE, field: 1'b0, text_byte: 8'd0};
					b_d.count = 3'd1;
					phase_d = PH_IDLE;
				end else if (byte_count_d >= 4'd4) begin
					byte_count_d = '0;
					ext_left_d = (ext_new > 32'd4) ? ext_new - 32'd4 : 32'd0;
					phase_d = (ext_new > 32'd4) ? PH_EXTSKIP : PH_FHDR;
				end
			end
			PH_EXTSKIP: begin
				tag_left_d = tl_dec;
				ext_left_d = ext_left_d - 32'd1;
				if (tl_dec == 32'd0) begin
					b_d.words[0] = '{kind: KIND_TAG_DONE, field: 1'b0, text_byte: 8'd0};
					b_d.count = 3'd1;
					phase_d = PH_IDLE;
				end else if (ext_left_d == 32'd0) begin
					phase_d = PH_FHDR;
				end
			end
			PH_FHDR: begin
				if (byte_count_d == 4'd0 && b == 8'd0) begin
					b_d.words[0] = '{kind: KIND_TAG_DONE, field: 1'b0, text_byte: 8'd0};
					b_d.count = 3'd1;
					phase_d = PH_IDLE;
				end else if (byte_count_d == 4'd0 &&
						(version_d < 8'd2 || version_d > 8'd4)) begin
					b_d.words[0] = '{kind: KIND_BAD_VER, field: 1'b0, text_byte: 8'd0};
					b_d.count = 3'd1;
					phase_d = PH_IDLE;
				end else begin
					if (byte_count_d == 4'd0) begin
						frame_id_d = '0;
						frame_left_d = '0;
					end
					if (byte_count_d < idlen)
						frame_id_d = {frame_id_d[23:0], b};
					else if (byte_count_d < {idlen[2:0], 1'b0}) begin
						if (version_d == 8'd4)
							frame_left_d = {frame_left_d[24:0], b[6:0]};
						else
							frame_left_d = {frame_left_d[23:0], b};
					end
					tag_left_d = tl_dec;
					byte_count_d = byte_count_d + 4'd1;
					if (tl_dec == 32'd0) begin
						b_d.words[0] = '{kind: KIND_TAG_DONE, field: 1'b0, text_byte: 8'd0};
						b_d.count = 3'd1;
						phase_d = PH_IDLE;
					end else if (byte_count_d >= hlen) begin
						fk_d = FK_UNKNOWN;
						if (version_d == 8'd2) begin
							if (frame_id_d == {8'd0, ID_TP1}) fk_d = FK_ARTIST;
							else if (frame_id_d == {8'd0, ID_TT2}) fk_d = FK_TITLE;
						end else begin
							if (frame_id_d == ID_TPE1) fk_d = FK_ARTIST;
							else if (frame_id_d == ID_TIT2) fk_d = FK_TITLE;
						end
						fl_new = (frame_left_d > tl_dec) ? tl_dec : frame_left_d;
						frame_left_d = fl_new;
						byte_count_d = '0; bom_d = BOM_NONE; held_d = '0;
						emitted_d = '0; stopped_d = 1'b0; enc_d = '0;
						if (fl_new == 32'd0) begin
							if (fk_d != FK_UNKNOWN) begin
								b_d.words[0] = '{kind: KIND_FIELD, field: (fk_d == FK_TITLE),
									text_byte: 8'd0};
								b_d.count = 3'd1;
							end
						end else begin
							phase_d = PH_FBODY;
						end
					end
				end
			end
			PH_FBODY: begin
				tag_left_d = tl_dec;
				frame_left_d = fl_dec;
				if (fk_known) begin
					if (byte_count_d == 4'd0) begin
						enc_d = b;
						byte_count_d = 4'd1;
					end else if (!stopped_d) begin
						unit_done = 1'b1;
						if (enc_d == 8'd1 || enc_d == 8'd2) begin
							if (byte_count_d == 4'd1) begin
								held_d = b;
								byte_count_d = 4'd2;
								unit_done = 1'b0;
							end else begin
								byte_count_d = 4'd1;
								if (enc_d == 8'd2) bom_d = BOM_BE;
								if (bom_d == BOM_NONE) begin
									if (held_d == 8'hFF && b == 8'hFE) bom_d = BOM_LE;
									else if (held_d == 8'hFE && b == 8'hFF) bom_d = BOM_BE;
								end else begin
									u = (bom_d == BOM_LE) ? {b, held_d} : {held_d, b};
									if (u <= 16'h007F) begin
										tx[0] = u[7:0]; ntx = 2'd1;
									end else if (u <= 16'h07FF) begin
										tx[0] = {3'b110, u[10:6]};
										tx[1] = {2'b10, u[5:0]}; ntx = 2'd2;
									end else begin
										tx[0] = {4'b1110, u[15:12]};
										tx[1] = {2'b10, u[11:6]};
										tx[2] = {2'b10, u[5:0]}; ntx = 2'd3;
									end
								end
							end
						end else begin
							tx[0] = b; ntx = 2'd1;
						end
						for (int i = 0; i < 3; i++) begin
							if (i < int'(ntx) && !stopped_d) begin
								if (tx[i] == 8'd0) begin
									stopped_d = 1'b1;
								end else begin
									b_d.words[b_d.count] = '{kind: KIND_TEXT, field: fld,
										text_byte: tx[i]};
									b_d.count = b_d.count + 3'd1;
									emitted_d = emitted_d + 8'd1;
								end
							end
						end
						if (unit_done) begin
							lim = {1'b0, emitted_d} + 9'd3;
							if (lim >= {1'b0, max_text_len}) stopped_d = 1'b1;
						end
					end
				end
				if (fl_dec == 32'd0) begin
					if (fk_known) begin
						b_d.words[b_d.count] = '{kind: KIND_FIELD, field: fld, text_byte: 8'd0};
						b_d.count = b_d.count + 3'd1;
					end
					byte_count_d = '0;
					if (tl_dec == 32'd0) begin
						b_d.words[b_d.count] = '{kind: KIND_TAG_DONE, field: 1'b0,
							text_byte: 8'd0};
						b_d.count = b_d.count + 3'd1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_FHDR;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; byte_count_q <= '0; version_q <= '0; flags_q <= '0;
			tag_left_q <= '0; ext_left_q <= '0; frame_id_q <= '0; frame_left_q <= '0;
			fk_q <= FK_UNKNOWN; enc_q <= '0; bom_q <= BOM_NONE; held_q <= '0;
			emitted_q <= '0; stopped_q <= 1'b0;
		end else if (in_valid) begin
			phase_q <= phase_d; byte_count_q <= byte_count_d; version_q <= version_d;
			flags_q <= flags_d; tag_left_q <= tag_left_d; ext_left_q <= ext_left_d;
			frame_id_q <= frame_id_d; frame_left_q <= frame_left_d; fk_q <= fk_d;
			enc_q <= enc_d; bom_q <= bom_d; held_q <= held_d;
			emitted_q <= emitted_d; stopped_q <= stopped_d;
		end
	end

	assign batch_valid = in_valid && (b_d.count != 3'd0);
	assign batch = b_d;

endmodule

/* rtl/id3_back.sv */
// Back part: queues batches of result words, delivering one word a cycle unless stalled.
`timescale 1ns / 1ps
module id3_back import id3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  batch_t    batch,
	output logic      room,
	output logic      out_valid,
	output out_word_t out_word,
	input  logic      out_stall
);

	batch_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_q;
	logic [QUEUE_AW-1:0]   rd_q;
	logic [QUEUE_AW:0]     fill_q;
	logic [2:0]            pos_q;
	logic                  pop;
	batch_t                head;

	assign head = mem_q[rd_q];
	assign out_valid = (fill_q != '0);
	assign out_word = head.words[pos_q];
	assign pop = out_valid && !out_stall && (pos_q + 3'd1 == head.count);
	// Room for a batch is judged conservatively so input never waits on a pop.
	assign room = (fill_q < (QUEUE_AW + 1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= batch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; fill_q <= '0; pos_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) begin
				rd_q <= rd_q + 1'b1;
				pos_q <= '0;
			end else if (out_valid && !out_stall) begin
				pos_q <= pos_q + 3'd1;
			end
			fill_q <= fill_q + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
		end
	end

endmodule

/* rtl/id3_checker.sv */
// Port-level checker for the ID3v2 text frame extractor, bound to the top level.
`timescale 1ns / 1ps
module id3_checker import id3_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("Stalled result word changed.");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.kind <= KIND_BAD_VER)
		else $error("Result kind out of range.");

	a_text_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_TEXT |-> out_data.text_byte != 8'd0)
		else $error("Zero text byte emitted.");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != KIND_TEXT |-> out_data.text_byte == 8'd0)
		else $error("Non-text word carries a byte.");

endmodule

bind id3v2_text_frame_extractor_unit id3_checker u_id3_checker (
	.clk, .arst_n, .out_valid, .out_stall, .out_data
);
